// File: src/spe_pkg.sv
// Package for the stop path evaluator: sizes, request codes and the
// control record passed from the front end to the accumulator.
// No dependencies.
package spe_pkg;

	localparam int VERTICES    = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int VIDX_W      = 6;
	localparam int CFG_W       = 64;
	localparam int DEPTH       = VERTICES * VERTICES;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int SUM_W       = 22;
	localparam int SUM_EXT_W   = ((SUM_W > WEIGHT_BITS) ? SUM_W : WEIGHT_BITS) + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_PATH  = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic stop;
		logic last;
		logic in_range;
	} path_ctl_t;

endpackage

// File: src/spe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/spe_front.sv
// Front end: accepts items, forms weight store addresses, tracks the previous
// path vertex and registers the per-vertex control. Uses spe_pkg.
module spe_front import spe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   req_type,
	input  logic [VIDX_W-1:0]      row_index,
	input  logic [VIDX_W-1:0]      col_index,
	input  logic [15:0]            edge_weight,
	input  logic [VIDX_W-1:0]      path_vertex,
	input  logic                   last_vertex,
	input  logic [CFG_W-1:0]       stop_mask_q,
	output logic                   wr_en,
	output logic [ADDR_W-1:0]      wr_addr,
	output logic [WEIGHT_BITS-1:0] wr_data,
	output logic                   rd_en,
	output logic [ADDR_W-1:0]      rd_addr,
	output path_ctl_t              ctl_s1
);

	logic              accept;
	logic              accept_path;
	logic              in_path_q;
	logic [VIDX_W-1:0] prev_q;
	logic              wr_in_range;
	logic              rd_in_range;
	logic              v_in_range;
	logic              stop;

	assign accept      = in_valid && !in_stall;
	assign accept_path = accept && (req_type == REQ_PATH);

	assign wr_in_range = (32'(row_index) < 32'(VERTICES)) && (32'(col_index) < 32'(VERTICES));
	assign v_in_range  = 32'(path_vertex) < 32'(VERTICES);
	assign rd_in_range = (32'(prev_q) < 32'(VERTICES)) && v_in_range;
	assign stop        = v_in_range && stop_mask_q[path_vertex];

	assign wr_en   = accept && (req_type == REQ_WRITE) && wr_in_range;
	assign wr_addr = ADDR_W'(row_index) * ADDR_W'(VERTICES) + ADDR_W'(col_index);
	assign wr_data = WEIGHT_BITS'(edge_weight);
	assign rd_en   = accept_path && in_path_q && rd_in_range;
	assign rd_addr = ADDR_W'(prev_q) * ADDR_W'(VERTICES) + ADDR_W'(path_vertex);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_path_q <= 1'b0;
			prev_q    <= '0;
			ctl_s1    <= '0;
		end else if (!in_stall) begin
			ctl_s1.valid <= accept_path;
			if (accept_path) begin
				in_path_q       <= !last_vertex;
				prev_q          <= path_vertex;
				ctl_s1.first    <= !in_path_q;
				ctl_s1.stop     <= stop;
				ctl_s1.last     <= last_vertex;
				ctl_s1.in_range <= rd_in_range;
			end
		end
	end

endmodule

// File: src/spe_accum.sv
// Accumulator: sums edge weights read from the weight store, tracks the best
// segment and validity, and holds the result item in an output register.
// Uses spe_pkg.
module spe_accum import spe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  path_ctl_t              ctl_s1,
	input  logic [WEIGHT_BITS-1:0] rd_data,
	input  logic                   out_stall,
	output logic                   hold,
	output logic                   out_valid,
	output logic                   path_valid,
	output logic [SUM_W-1:0]       max_segment
);

	logic                 run_ok_q;
	logic                 start_stop_q;
	logic [SUM_W-1:0]     run_q;
	logic [SUM_W-1:0]     best_q;
	logic                 out_valid_q;
	logic                 commit;
	logic [WEIGHT_BITS-1:0] w;
	logic [SUM_EXT_W-1:0] sum;
	logic [SUM_W-1:0]     sum_sat;
	logic                 ok_nxt;
	logic                 start_nxt;
	logic [SUM_W-1:0]     run_nxt;
	logic [SUM_W-1:0]     best_nxt;

	assign hold   = ctl_s1.valid && ctl_s1.last && out_valid_q && out_stall;
	assign commit = ctl_s1.valid && !hold;

	assign w       = ctl_s1.in_range ? rd_data : '0;
	assign sum     = SUM_EXT_W'(run_q) + SUM_EXT_W'(w);
	assign sum_sat = (sum > SUM_EXT_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum);

	always_comb begin
		if (ctl_s1.first) begin
			ok_nxt    = 1'b1;
			start_nxt = ctl_s1.stop;
			run_nxt   = '0;
			best_nxt  = '0;
		end else begin
			ok_nxt    = run_ok_q && (w != '0);
			start_nxt = start_stop_q;
			if (ctl_s1.stop) begin
				run_nxt  = '0;
				best_nxt = (sum_sat > best_q) ? sum_sat : best_q;
			end else begin
				run_nxt  = sum_sat;
				best_nxt = best_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_ok_q     <= 1'b1;
			start_stop_q <= 1'b0;
			run_q        <= '0;
			best_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit && ctl_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (ctl_s1.last) begin
					run_ok_q     <= 1'b1;
					start_stop_q <= 1'b0;
					run_q        <= '0;
					best_q       <= '0;
				end else begin
					run_ok_q     <= ok_nxt;
					start_stop_q <= start_nxt;
					run_q        <= run_nxt;
					best_q       <= best_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && ctl_s1.last) begin
			path_valid  <= ok_nxt && start_nxt && ctl_s1.stop;
			max_segment <= best_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/stop_path_evaluator.sv
// Stop path evaluator top level: weight store RAM, front end, accumulator and
// stop mask register. Uses spe_pkg, spe_ram, spe_front and spe_accum.
// Throughput: one item per cycle when not stalled. A last vertex's result is
// registered in ctl_s1, then in the output register. The input stalls only while
// a last-vertex result waits behind a stalled output item. Reset clears all
// control state and the stop mask; the weight store is undefined until written.
module stop_path_evaluator import spe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [VIDX_W-1:0] row_index,
	input  logic [VIDX_W-1:0] col_index,
	input  logic [15:0]       edge_weight,
	input  logic [VIDX_W-1:0] path_vertex,
	input  logic              last_vertex,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  stop_mask,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              path_valid,
	output logic [SUM_W-1:0]  max_segment
);

	logic [CFG_W-1:0]       stop_mask_q;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [WEIGHT_BITS-1:0] wr_data;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [WEIGHT_BITS-1:0] rd_data;
	path_ctl_t              ctl_s1;
	logic                   hold;

	assign cfg_ready = 1'b1;
	assign in_stall  = hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			stop_mask_q <= stop_mask;
		end
	end

	spe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.row_index   (row_index),
		.col_index   (col_index),
		.edge_weight (edge_weight),
		.path_vertex (path_vertex),
		.last_vertex (last_vertex),
		.stop_mask_q (stop_mask_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.ctl_s1      (ctl_s1)
	);

	spe_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_weights (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	spe_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s1      (ctl_s1),
		.rd_data     (rd_data),
		.out_stall   (out_stall),
		.hold        (hold),
		.out_valid   (out_valid),
		.path_valid  (path_valid),
		.max_segment (max_segment)
	);

endmodule
